FILE: design/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// Types and constants shared by the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

	localparam int OP_W    = 5;
	localparam int DATA_W  = 8;
	localparam int WIDE_W  = 16;
	localparam int FLAG_W  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC8  = 5'd8,
		OP_DEC8  = 5'd9,
		OP_DAA   = 5'd10,
		OP_CPL   = 5'd11,
		OP_SCF   = 5'd12,
		OP_CCF   = 5'd13,
		OP_ADD16 = 5'd14,
		OP_INC16 = 5'd15,
		OP_DEC16 = 5'd16
	} op_t;

	// flag bit positions
	localparam int FL_S  = 7;
	localparam int FL_Z  = 6;
	localparam int FL_H  = 4;
	localparam int FL_PV = 2;
	localparam int FL_N  = 1;
	localparam int FL_C  = 0;

	localparam logic [FLAG_W-1:0] FLAG_MASK  = 8'hD7;
	localparam logic [FLAG_W-1:0] FLAG_RESET = 8'hD7;
	localparam logic [DATA_W-1:0] ACC_RESET  = 8'hFF;

	localparam logic [DATA_W-1:0] DAA_LIMIT  = 8'h99;
	localparam logic [3:0]        DAA_NIB    = 4'h9;
	localparam logic [DATA_W-1:0] DAA_LO_ADJ = 8'h06;
	localparam logic [DATA_W-1:0] DAA_HI_ADJ = 8'h60;
	localparam logic [DATA_W-1:0] INC_OVF    = 8'h7F;
	localparam logic [DATA_W-1:0] DEC_OVF    = 8'h80;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic [WIDE_W-1:0] wide_result;
		logic [FLAG_W-1:0] flags;
		logic              acc_we;
	} core_out_t;

endpackage

FILE: design/alu8f_req_if.sv
// ----------------------------------------------------------------------------
// alu8f_req_if
// Request channel: operation code and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alu8f_req_if;
	import alu8f_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [DATA_W-1:0] operand;
	logic [WIDE_W-1:0] wide_left;
	logic [WIDE_W-1:0] wide_right;

	modport source (output valid, output op, output operand, output wide_left,
		output wide_right, input ready);
	modport sink (input valid, input op, input operand, input wide_left,
		input wide_right, output ready);

endinterface

FILE: design/alu8f_rsp_if.sv
// ----------------------------------------------------------------------------
// alu8f_rsp_if
// Response channel: 8-bit result, 16-bit result and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alu8f_rsp_if;
	import alu8f_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result;
	logic [WIDE_W-1:0] wide_result;
	logic [FLAG_W-1:0] flag_bits;

	modport source (output valid, output result, output wide_result,
		output flag_bits, input ready);
	modport sink (input valid, input result, input wide_result,
		input flag_bits, output ready);

endinterface

FILE: design/eight_bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Eight-bit ALU with accumulator and flag register, registered in and out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  req      in         valid/ready    op, operand, wide_left, wide_right
//  rsp      out        valid/ready    result, wide_result, flag_bits
//
//  One transaction per cycle sustained while rsp is ready; a request that is taken
//  passes the input register, then the result register, from which rsp offers
//  its result.
//  The accumulator and flags update as an operation leaves the input register,
//  so the following operation sees them in the next cycle.
//  Reset sets the accumulator to 0xFF and the flags to 0xD7, both stages empty.
//  A stalled rsp holds the result register; req keeps flowing until the input
//  register is full too.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
	input  logic           clk,
	input  logic           arst_n,
	alu8f_req_if.sink      req,
	alu8f_rsp_if.source    rsp
);
	import alu8f_pkg::*;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [DATA_W-1:0] operand_s1;
	logic [WIDE_W-1:0] wide_left_s1;
	logic [WIDE_W-1:0] wide_right_s1;

	logic              valid_s2;
	logic [DATA_W-1:0] result_s2;
	logic [WIDE_W-1:0] wide_result_s2;
	logic [FLAG_W-1:0] flag_bits_s2;

	logic [DATA_W-1:0] acc_q;
	logic [FLAG_W-1:0] flag_q;

	logic              advance;
	logic              take;
	core_out_t         core_out;

	assign advance   = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | advance;
	assign take      = req.valid & req.ready;

	alu8f_core u_core (
		.op         (op_s1),
		.operand    (operand_s1),
		.wide_left  (wide_left_s1),
		.wide_right (wide_right_s1),
		.acc        (acc_q),
		.flags      (flag_q),
		.core_out   (core_out)
	);

	// hold the input register until the core result can move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1         <= req.op;
			operand_s1    <= req.operand;
			wide_left_s1  <= req.wide_left;
			wide_right_s1 <= req.wide_right;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= ACC_RESET;
			flag_q <= FLAG_RESET;
		end else if (advance) begin
			if (core_out.acc_we) begin
				acc_q <= core_out.result;
			end
			flag_q <= core_out.flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2      <= core_out.result;
			wide_result_s2 <= core_out.wide_result;
			flag_bits_s2   <= core_out.flags;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.result      = result_s2;
	assign rsp.wide_result = wide_result_s2;
	assign rsp.flag_bits   = flag_bits_s2;

endmodule

FILE: design/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core
// Datapath: arithmetic, logic, decimal adjust and 16-bit operations with flag
// generation for one operation against the current accumulator and flags.
// ----------------------------------------------------------------------------
module alu8f_core (
	input  logic [alu8f_pkg::OP_W-1:0]   op,
	input  logic [alu8f_pkg::DATA_W-1:0] operand,
	input  logic [alu8f_pkg::WIDE_W-1:0] wide_left,
	input  logic [alu8f_pkg::WIDE_W-1:0] wide_right,
	input  logic [alu8f_pkg::DATA_W-1:0] acc,
	input  logic [alu8f_pkg::FLAG_W-1:0] flags,
	output alu8f_pkg::core_out_t         core_out
);
	import alu8f_pkg::*;

	logic              cin;
	logic              c;
	logic [DATA_W:0]   add9;
	logic [4:0]        add_h5;
	logic              add_v;
	logic [DATA_W:0]   sub9;
	logic [4:0]        sub_h5;
	logic              sub_v;
	logic [DATA_W-1:0] and_r;
	logic [DATA_W-1:0] xor_r;
	logic [DATA_W-1:0] or_r;
	logic [DATA_W-1:0] inc_r;
	logic [DATA_W-1:0] dec_r;
	logic              daa_lo;
	logic              daa_hi;
	logic [DATA_W-1:0] daa_diff;
	logic [DATA_W-1:0] daa_r;
	logic [WIDE_W:0]   add17;
	logic [12:0]       add_h13;
	logic [FLAG_W-1:0] fl;
	logic [DATA_W-1:0] res;
	logic [WIDE_W-1:0] wide;
	logic              we;

	assign cin = flags[FL_C];
	assign c   = cin & ((op_t'(op) == OP_ADC) | (op_t'(op) == OP_SBC));

	assign add9   = {1'b0, acc} + {1'b0, operand} + {{DATA_W{1'b0}}, c};
	assign add_h5 = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'b0, c};
	assign add_v  = ~(acc[7] ^ operand[7]) & (acc[7] ^ add9[7]);

	assign sub9   = {1'b0, acc} - {1'b0, operand} - {{DATA_W{1'b0}}, c};
	assign sub_h5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'b0, c};
	assign sub_v  = (acc[7] ^ operand[7]) & (acc[7] ^ sub9[7]);

	assign and_r = acc & operand;
	assign xor_r = acc ^ operand;
	assign or_r  = acc | operand;
	assign inc_r = operand + 8'd1;
	assign dec_r = operand - 8'd1;

	assign daa_lo   = flags[FL_H] | (acc[3:0] > DAA_NIB);
	assign daa_hi   = cin | (acc > DAA_LIMIT);
	assign daa_diff = (daa_lo ? DAA_LO_ADJ : '0) | (daa_hi ? DAA_HI_ADJ : '0);
	assign daa_r    = flags[FL_N] ? (acc - daa_diff) : (acc + daa_diff);

	assign add17   = {1'b0, wide_left} + {1'b0, wide_right};
	assign add_h13 = {1'b0, wide_left[11:0]} + {1'b0, wide_right[11:0]};

	always_comb begin
		res  = acc;
		wide = '0;
		we   = 1'b0;
		fl   = flags;
		unique case (op_t'(op))
			OP_ADD, OP_ADC: begin
				res = add9[DATA_W-1:0];
				we  = 1'b1;
				fl  = '0;
				fl[FL_S]  = add9[7];
				fl[FL_Z]  = (add9[DATA_W-1:0] == '0);
				fl[FL_H]  = add_h5[4];
				fl[FL_PV] = add_v;
				fl[FL_C]  = add9[DATA_W];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (op_t'(op) != OP_CP) begin
					res = sub9[DATA_W-1:0];
					we  = 1'b1;
				end
				fl = '0;
				fl[FL_S]  = sub9[7];
				fl[FL_Z]  = (sub9[DATA_W-1:0] == '0);
				fl[FL_H]  = sub_h5[4];
				fl[FL_PV] = sub_v;
				fl[FL_N]  = 1'b1;
				fl[FL_C]  = sub9[DATA_W];
			end
			OP_AND, OP_XOR, OP_OR: begin
				we  = 1'b1;
				res = (op_t'(op) == OP_AND) ? and_r :
					(op_t'(op) == OP_XOR) ? xor_r : or_r;
				fl  = '0;
				fl[FL_S]  = res[7];
				fl[FL_Z]  = (res == '0);
				fl[FL_H]  = (op_t'(op) == OP_AND);
				fl[FL_PV] = ~^res;
			end
			OP_INC8: begin
				res = inc_r;
				fl  = '0;
				fl[FL_S]  = inc_r[7];
				fl[FL_Z]  = (inc_r == '0);
				fl[FL_H]  = (operand[3:0] == 4'hF);
				fl[FL_PV] = (operand == INC_OVF);
				fl[FL_C]  = cin;
			end
			OP_DEC8: begin
				res = dec_r;
				fl  = '0;
				fl[FL_S]  = dec_r[7];
				fl[FL_Z]  = (dec_r == '0);
				fl[FL_H]  = (operand[3:0] == 4'h0);
				fl[FL_PV] = (operand == DEC_OVF);
				fl[FL_N]  = 1'b1;
				fl[FL_C]  = cin;
			end
			OP_DAA: begin
				res = daa_r;
				we  = 1'b1;
				fl  = '0;
				fl[FL_S]  = daa_r[7];
				fl[FL_Z]  = (daa_r == '0);
				fl[FL_H]  = acc[4] ^ daa_r[4];
				fl[FL_PV] = ~^daa_r;
				fl[FL_N]  = flags[FL_N];
				fl[FL_C]  = daa_hi;
			end
			OP_CPL: begin
				res = ~acc;
				we  = 1'b1;
				fl[FL_H] = 1'b1;
				fl[FL_N] = 1'b1;
			end
			OP_SCF: begin
				fl[FL_H] = 1'b0;
				fl[FL_N] = 1'b0;
				fl[FL_C] = 1'b1;
			end
			OP_CCF: begin
				fl[FL_H] = cin;
				fl[FL_N] = 1'b0;
				fl[FL_C] = ~cin;
			end
			OP_ADD16: begin
				wide = add17[WIDE_W-1:0];
				fl[FL_H] = add_h13[12];
				fl[FL_N] = 1'b0;
				fl[FL_C] = add17[WIDE_W];
			end
			OP_INC16: begin
				wide = wide_left + 16'd1;
			end
			OP_DEC16: begin
				wide = wide_left - 16'd1;
			end
			default: begin
				res = acc;
			end
		endcase
	end

	assign core_out.result      = res;
	assign core_out.wide_result = wide;
	assign core_out.flags       = fl & FLAG_MASK;
	assign core_out.acc_we      = we;

endmodule
